@@ src/mie_pkg.sv @@
// package for the modular inverse block: widths and sequencer states
// no dependencies
package mie_pkg;

    // width of every port field
    localparam int DATA_W = 64;
    // default operand width
    localparam int DEF_WIDTH = 64;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_UPDATE = 5'b10000
    } t_state;

endpackage

@@ src/modular_inverse_euclid.sv @@
// An item is reduced by the modulus, then runs Euclid steps (check, divide, update) until
// the new remainder is zero, when the result strobe is raised; at most about 93 steps for
// 64-bit operands. One restoring divider, one quotient bit per cycle, is shared by the
// initial reduction and every step. Throughput: one item at a time; busy is high from
// accept until the result strobe; a zero modulus answers in the next cycle with busy low.
// Reset (synchronous, active low) clears the sequencer and sets the modulus to one.
// top level of the modular inverse block, extended Euclid on a shared divider
// depends on mie_pkg
module modular_inverse_euclid #(
    parameter int WIDTH = mie_pkg::DEF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mie_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mie_pkg::DATA_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    output logic [mie_pkg::DATA_W-1:0]  o_inverse,
    output logic                        o_not_invertible
);
    import mie_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    t_state             r_state, n_state;
    logic [WIDTH-1:0]   r_mod;
    logic [WIDTH-1:0]   r_m, n_m;
    logic [WIDTH-1:0]   r_r, n_r;
    logic [WIDTH-1:0]   r_nr, n_nr;
    logic [WIDTH-1:0]   r_t, n_t;
    logic [WIDTH-1:0]   r_nt, n_nt;
    logic               r_tneg, n_tneg;
    logic [WIDTH-1:0]   r_rem, n_rem;
    logic [WIDTH-1:0]   r_quo, n_quo;
    logic [WIDTH-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_valid, n_valid;
    logic [DATA_W-1:0]  r_inv, n_inv;
    logic               r_flag, n_flag;

    // shared divider datapath
    logic [WIDTH:0]     shift_rem;
    logic [WIDTH:0]     trial;
    logic               qbit;
    logic [WIDTH-1:0]   den;
    logic [WIDTH:0]     acc_next;
    logic [WIDTH-1:0]   tmod;
    logic [WIDTH-1:0]   res;

    // divisor is the modulus while reducing, the new remainder while stepping
    assign den       = (r_state == ST_REDUCE) ? r_m : r_nr;
    assign shift_rem = {r_rem, r_quo[WIDTH-1]};
    assign trial     = shift_rem - {1'b0, den};
    assign qbit      = ~trial[WIDTH];
    // coefficient product accumulated one quotient bit at a time
    assign acc_next  = {r_acc, 1'b0} + (qbit ? {1'b0, r_nt} : '0);

    // final normalization, coefficient magnitude never exceeds the modulus
    assign tmod = (r_t == r_m) ? '0 : r_t;
    assign res  = (!r_tneg && tmod != '0) ? (r_m - tmod) : tmod;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_r     = r_r;
        n_nr    = r_nr;
        n_t     = r_t;
        n_nt    = r_nt;
        n_tneg  = r_tneg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_inv   = r_inv;
        n_flag  = r_flag;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_m = r_mod;
                    if (r_mod == '0) begin
                        n_valid = 1'b1;
                        n_inv   = '0;
                        n_flag  = 1'b1;
                    end else begin
                        n_quo   = i_value[WIDTH-1:0];
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                n_rem = qbit ? trial[WIDTH-1:0] : shift_rem[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    n_nr    = qbit ? trial[WIDTH-1:0] : shift_rem[WIDTH-1:0];
                    n_r     = r_m;
                    n_t     = '0;
                    n_nt    = WIDTH'(1);
                    n_tneg  = 1'b0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_nr == '0) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                    if (r_r != WIDTH'(1)) begin
                        n_inv  = '0;
                        n_flag = 1'b1;
                    end else begin
                        n_inv  = DATA_W'(res);
                        n_flag = 1'b0;
                    end
                end else begin
                    n_quo   = r_r;
                    n_rem   = '0;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = qbit ? trial[WIDTH-1:0] : shift_rem[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], qbit};
                n_acc = acc_next[WIDTH-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // rotate remainder and coefficient pairs
                n_r     = r_nr;
                n_nr    = r_rem;
                n_t     = r_nt;
                n_nt    = r_acc + r_t;
                n_tneg  = ~r_tneg;
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_mod   <= WIDTH'(1);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_valid) begin
                r_mod <= i_cfg_data[WIDTH-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_r    <= n_r;
        r_nr   <= n_nr;
        r_t    <= n_t;
        r_nt   <= n_nt;
        r_tneg <= n_tneg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_inv  <= n_inv;
        r_flag <= n_flag;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_valid;
    assign o_inverse        = r_inv;
    assign o_not_invertible = r_flag;

endmodule

@@ tb/tb_top.sv @@
// testbench for modular_inverse_euclid: directed table, then random values over several moduli
// depends on mie_pkg and modular_inverse_euclid
`timescale 1ns / 100ps

module tb_top;

    import mie_pkg::*;

    localparam int WIDTH = DEF_WIDTH;
    localparam int WDOG_LIMIT = 40000;
    localparam int NUM_VEC = 20;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam logic [DATA_W-1:0] TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

    typedef struct packed {
        logic [DATA_W-1:0] inverse;
        logic              not_invertible;
    } t_inv_result;

    typedef struct {
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] value;
        logic              known;
        t_inv_result       result;
    } t_vector;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [DATA_W-1:0] i_value;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DATA_W-1:0] i_cfg_data;
    logic              o_valid;
    logic [DATA_W-1:0] o_inverse;
    logic              o_not_invertible;

    t_inv_result       inverse_queue[$];
    logic [DATA_W-1:0] cur_modulus;
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    int                send_idle_pct;
    t_vector           vec_table[NUM_VEC];

    modular_inverse_euclid #(.WIDTH(WIDTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_value         (i_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_inverse       (o_inverse),
        .o_not_invertible(o_not_invertible)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // extended euclid with alternating-sign coefficient magnitudes
    function automatic t_inv_result calc_inverse(logic [DATA_W-1:0] m_in,
                                                 logic [DATA_W-1:0] v_in);
        logic [WIDTH-1:0] m, r, nr, t, nt, q, tmp;
        logic             t_neg;
        t_inv_result      res;
        m = m_in[WIDTH-1:0];
        res = '{inverse: '0, not_invertible: 1'b1};
        if (m == '0) return res;
        r = m;
        nr = v_in[WIDTH-1:0] % m;
        t = '0;
        nt = WIDTH'(1);
        t_neg = 1'b0;
        while (nr != '0) begin
            q = r / nr;
            tmp = r - q * nr;
            r = nr;
            nr = tmp;
            tmp = t + q * nt;
            t = nt;
            nt = tmp;
            t_neg = ~t_neg;
        end
        if (r != WIDTH'(1)) return res;
        tmp = t % m;
        if (!t_neg && tmp != '0) tmp = m - tmp;
        res.inverse = DATA_W'(tmp);
        res.not_invertible = 1'b0;
        return res;
    endfunction

    // random 64-bit value with a random bit length
    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] w;
        int                len;
        w = {$urandom, $urandom};
        len = $urandom_range(1, DATA_W);
        if (len < DATA_W) w = w & ((64'd1 << len) - 64'd1);
        return w;
    endfunction

    // result checker, watchdog on accepted traffic
    always @(posedge i_clk) begin
        t_inv_result exp_res;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (o_valid) begin
                if (inverse_queue.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result inverse=%h flag=%b",
                                 o_inverse, o_not_invertible);
                end else begin
                    exp_res = inverse_queue.pop_front();
                    if (o_inverse !== exp_res.inverse
                        || o_not_invertible !== exp_res.not_invertible) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch inverse exp=%h got=%h flag exp=%b got=%b",
                                     exp_res.inverse, o_inverse,
                                     exp_res.not_invertible, o_not_invertible);
                    end
                end
            end
        end
    end

    // write the modulus register, block must be idle
    task automatic write_modulus(logic [DATA_W-1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_modulus = m;
    endtask

    // send one item, optionally idling first; start stays high until the next idle
    task automatic send_value(logic [DATA_W-1:0] v, logic known, t_inv_result res);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_value <= v;
        inverse_queue.insert(inverse_queue.size(),
                             known ? res : calc_inverse(cur_modulus, v));
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and wait for every expected item
    task automatic drain();
        start <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_vector mk(logic [DATA_W-1:0] m, logic [DATA_W-1:0] v,
                                   logic known, logic [DATA_W-1:0] inv, logic flag);
        t_vector tv;
        tv.modulus = m;
        tv.value = v;
        tv.known = known;
        tv.result = '{inverse: inv, not_invertible: flag};
        return tv;
    endfunction

    // main sequence
    initial begin
        logic [DATA_W-1:0] m_list[6];
        start = 1'b0;
        i_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        cur_modulus = 64'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: modulus one after reset, zero modulus, multiples, extremes
        vec_table[0]  = mk(64'd1, ALL_ONES, 1'b1, 64'd0, 1'b0);
        vec_table[1]  = mk(64'd1, 64'd0, 1'b1, 64'd0, 1'b0);
        vec_table[2]  = mk(64'd0, 64'd5, 1'b1, 64'd0, 1'b1);
        vec_table[3]  = mk(64'd0, 64'd0, 1'b1, 64'd0, 1'b1);
        vec_table[4]  = mk(64'd7, 64'd0, 1'b1, 64'd0, 1'b1);
        vec_table[5]  = mk(64'd7, 64'd14, 1'b1, 64'd0, 1'b1);
        vec_table[6]  = mk(64'd7, 64'd1, 1'b1, 64'd1, 1'b0);
        vec_table[7]  = mk(64'd7, 64'd6, 1'b1, 64'd6, 1'b0);
        vec_table[8]  = mk(64'd7, 64'd3, 1'b1, 64'd5, 1'b0);
        vec_table[9]  = mk(64'd12, 64'd8, 1'b1, 64'd0, 1'b1);
        vec_table[10] = mk(ALL_ONES, ALL_ONES, 1'b1, 64'd0, 1'b1);
        vec_table[11] = mk(ALL_ONES, 64'd1, 1'b1, 64'd1, 1'b0);
        vec_table[12] = mk(ALL_ONES, 64'd2, 1'b0, 64'd0, 1'b0);
        vec_table[13] = mk(ALL_ONES, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0);
        vec_table[14] = mk(TOP_PRIME, ALL_ONES, 1'b0, 64'd0, 1'b0);
        vec_table[15] = mk(TOP_PRIME, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 1'b0);
        vec_table[16] = mk(TOP_PRIME, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 1'b0);
        vec_table[17] = mk(TOP_PRIME, TOP_PRIME - 64'd1, 1'b1, TOP_PRIME - 64'd1, 1'b0);
        vec_table[18] = mk(64'd2, 64'd1, 1'b1, 64'd1, 1'b0);
        vec_table[19] = mk(64'hB7E1_5162_8AED_2A6B, 64'h9E37_79B9_7F4A_7C15,
                           1'b0, 64'd0, 1'b0);

        foreach (vec_table[i]) begin
            if (vec_table[i].modulus != cur_modulus) begin
                drain();
                write_modulus(vec_table[i].modulus);
            end
            send_value(vec_table[i].value, vec_table[i].known, vec_table[i].result);
        end

        // random part over several moduli, idling profile per phase
        m_list = '{TOP_PRIME, ALL_ONES, 64'd1, 64'd97, 64'd0, 64'd0};
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 70 : 0;
            drain();
            write_modulus((ph >= 4) ? (rand_word() | 64'd1) : m_list[ph]);
            for (int n = 0; n < 14; n++) begin
                if ($urandom_range(3) == 0)
                    send_value(rand_word() * cur_modulus, 1'b0, '0);
                else
                    send_value({$urandom, $urandom} >> $urandom_range(0, 63), 1'b0, '0);
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ modular_inverse_euclid.f @@
src/mie_pkg.sv
src/modular_inverse_euclid.sv
tb/tb_top.sv
